### rtl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define WSWR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("weighted sampler assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define WSWR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("weighted sampler forbidden condition seen");

`else

`define WSWR_ASSERT(lbl, clk, rstn, prop)
`define WSWR_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### rtl/wswr_pkg.sv
package wswr_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES   = 32;
  localparam int WEIGHT_BITS   = 16;
  localparam int RESET_ENTRIES = 32;
  localparam int IDX_W         = $clog2(MAX_ENTRIES);
  localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W         = WEIGHT_BITS + IDX_W;

  // Field widths on the ports.
  localparam int CMD_W    = 2;
  localparam int ENTRY_W  = 5;
  localparam int WVAL_W   = 16;
  localparam int DCOUNT_W = 6;
  localparam int FRAC_W   = 16;
  localparam int CHOSEN_W = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 6;
  localparam int PROD_W   = SUM_W + FRAC_W;

  // Input beat layout, lowest field first.
  localparam int ENTRY_LSB  = 0;
  localparam int WVAL_LSB   = ENTRY_LSB + ENTRY_W;
  localparam int DCOUNT_LSB = WVAL_LSB + WVAL_W;
  localparam int FRAC_LSB   = DCOUNT_LSB + DCOUNT_W;
  localparam int S_FIELDS_W = FRAC_LSB + FRAC_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((CHOSEN_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_DRAWS  = 2'd1,
    STAT_NO_WEIGHT = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BURST = 6'b000010,
    S_SUM   = 6'b000100,
    S_MUL   = 6'b001000,
    S_WALK  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  // Number of entries taking part: zero counts as one, large values saturate.
  function automatic logic [CNT_W-1:0] live_entries(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (int'(cfg) > MAX_ENTRIES) begin
      n = CNT_W'(MAX_ENTRIES);
    end else begin
      n = CNT_W'(cfg);
    end
    return n;
  endfunction

endpackage

### rtl/weighted_sampler_without_replacement.sv
// Weighted sampler without replacement. Weights are loaded one entry at a time
// (cmd 0); cmd 1 begins a round with a draw count and marks the first
// entries_in_use entries as active, or, when the count is at least that number,
// streams every index in use from 0 upward as a burst of one result beat per cycle
// while the result stream takes them; cmd 2 draws one active entry with probability
// proportional to its weight and removes it from the round, or returns a status
// when no draws are left or the active weights sum to zero. For a draw, the single
// read port of the weight RAM is swept once, one entry per cycle, to sum the
// active weights, the multiplier scales the uniform fraction by that sum, and a
// second sweep walks the running sum until it passes the threshold. The input
// side is ready only while the sequencer is idle; a finished result waits in the
// output register, so the next beat may be taken while it does. A weight that
// was never loaded reads as an arbitrary value.
`include "assert_macros.svh"

module weighted_sampler_without_replacement (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: entries_in_use.
  input  logic                           cfg_we_i,
  input  logic [wswr_pkg::CFG_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // entry_index[4:0], weight_value[20:5], draw_count[26:21],
  // uniform_fraction[42:27], zero padding above.
  input  logic [wswr_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // cmd[1:0].
  input  logic [wswr_pkg::CMD_W-1:0]     s_axis_tuser_i,
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // chosen_index[4:0], zero padding above.
  output logic [wswr_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // status[1:0].
  output logic [wswr_pkg::STATUS_W-1:0]  m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  import wswr_pkg::*;

  state_e                  state_q, state_d;
  logic [CFG_W-1:0]        cfg_n_q;
  logic [MAX_ENTRIES-1:0]  active_q, active_d;
  logic [DCOUNT_W-1:0]     draws_q, draws_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
  logic [SUM_W-1:0]        acc_q, acc_d;
  logic [SUM_W-1:0]        thr_q, thr_d;
  logic [FRAC_W-1:0]       frac_q, frac_d;
  logic [CHOSEN_W-1:0]     res_idx_q, res_idx_d;
  status_e                 res_stat_q, res_stat_d;
  logic                    res_last_q, res_last_d;
  logic                    out_valid_q, out_valid_d;
  logic [CHOSEN_W-1:0]     out_idx_q, out_idx_d;
  status_e                 out_stat_q, out_stat_d;
  logic                    out_last_q, out_last_d;

  cmd_e                    in_cmd;
  logic [ENTRY_W-1:0]      in_entry;
  logic [WVAL_W-1:0]       in_wval;
  logic [DCOUNT_W-1:0]     in_dcount;
  logic [FRAC_W-1:0]       in_frac;
  logic                    in_accept;
  logic                    out_free;
  logic [CNT_W-1:0]        begin_n;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [WEIGHT_BITS-1:0]  ram_wdata;
  logic [WEIGHT_BITS-1:0]  ram_rdata;

  logic                    rd_issue;
  logic [SUM_W-1:0]        run_sum;
  logic                    pend_active;
  logic                    pend_last;
  logic                    walk_hit;
  logic                    walk_done;
  logic [IDX_W-1:0]        walk_pick;
  logic [PROD_W-1:0]       product;

  // Unpack the input beat.
  assign in_cmd    = cmd_e'(s_axis_tuser_i);
  assign in_entry  = s_axis_tdata_i[ENTRY_LSB +: ENTRY_W];
  assign in_wval   = s_axis_tdata_i[WVAL_LSB +: WVAL_W];
  assign in_dcount = s_axis_tdata_i[DCOUNT_LSB +: DCOUNT_W];
  assign in_frac   = s_axis_tdata_i[FRAC_LSB +: FRAC_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  // The output register can take a new result this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign begin_n         = live_entries(cfg_n_q);

  // Weight loads go straight into the table; an index beyond it is dropped.
  assign ram_we    = in_accept && (in_cmd == CMD_LOAD) && (int'(in_entry) < MAX_ENTRIES);
  assign ram_waddr = IDX_W'(in_entry);
  assign ram_wdata = WEIGHT_BITS'(in_wval);

  wswr_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Both sweeps share one read pipeline: the counter addresses the RAM and the
  // entry read last cycle arrives together with its index in pend_idx_q.
  assign rd_issue    = (int'(cnt_q) < MAX_ENTRIES);
  assign run_sum     = acc_q + SUM_W'(ram_rdata);
  assign pend_active = pend_q && active_q[pend_idx_q];
  assign pend_last   = pend_q && (int'(pend_idx_q) == MAX_ENTRIES - 1);

  // The first active entry whose running sum passes the threshold is taken.
  // Should the walk run off the end, entry zero is taken instead.
  assign walk_hit    = pend_active && (run_sum > thr_q);
  assign walk_done   = walk_hit || pend_last;
  assign walk_pick   = walk_hit ? pend_idx_q : '0;

  // Threshold is floor(u * total / 2^16).
  assign product     = PROD_W'(frac_q) * PROD_W'(acc_q);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    draws_d     = draws_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    acc_d       = acc_q;
    thr_d       = thr_q;
    frac_d      = frac_q;
    res_idx_d   = res_idx_q;
    res_stat_d  = res_stat_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_idx_d   = out_idx_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_BEGIN: begin
              if (int'(in_dcount) >= int'(begin_n)) begin
                // Asking for every entry: emit them all in index order.
                active_d = '0;
                draws_d  = '0;
                n_d      = begin_n;
                cnt_d    = '0;
                state_d  = S_BURST;
              end else begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                  active_d[i] = (i < int'(begin_n));
                end
                draws_d = in_dcount;
              end
            end
            CMD_DRAW: begin
              if (draws_q == '0) begin
                res_idx_d  = '0;
                res_stat_d = STAT_NO_DRAWS;
                res_last_d = 1'b1;
                state_d    = S_EMIT;
              end else begin
                frac_d  = in_frac;
                cnt_d   = '0;
                pend_d  = 1'b0;
                acc_d   = '0;
                state_d = S_SUM;
              end
            end
            default: begin
              // Loads are written by the RAM port; the unused code is dropped.
            end
          endcase
        end
      end

      S_BURST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = CHOSEN_W'(cnt_q);
          out_stat_d  = STAT_OK;
          out_last_d  = (cnt_q == n_q - 1'b1);
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == n_q - 1'b1) begin
            state_d = S_IDLE;
          end
        end
      end

      S_SUM: begin
        if (rd_issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        pend_d     = rd_issue;
        pend_idx_d = cnt_q[IDX_W-1:0];
        if (pend_active) begin
          acc_d = run_sum;
        end
        if (pend_last) begin
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        if (acc_q == '0) begin
          res_idx_d  = '0;
          res_stat_d = STAT_NO_WEIGHT;
          res_last_d = 1'b1;
          state_d    = S_EMIT;
        end else begin
          thr_d   = product[FRAC_W +: SUM_W];
          acc_d   = '0;
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        if (rd_issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        pend_d     = rd_issue;
        pend_idx_d = cnt_q[IDX_W-1:0];
        if (pend_active) begin
          acc_d = run_sum;
        end
        if (walk_done) begin
          active_d[walk_pick] = 1'b0;
          draws_d    = draws_q - 1'b1;
          res_idx_d  = CHOSEN_W'(walk_pick);
          res_stat_d = STAT_OK;
          res_last_d = (draws_q == DCOUNT_W'(1));
          pend_d     = 1'b0;
          state_d    = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_stat_d  = res_stat_q;
          out_last_d  = res_last_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_n_q     <= CFG_W'(RESET_ENTRIES);
      active_q    <= '0;
      draws_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cfg_n_q <= cfg_data_i;
      end
      active_q    <= active_d;
      draws_q     <= draws_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    pend_idx_q <= pend_idx_d;
    acc_q      <= acc_d;
    thr_q      <= thr_d;
    frac_q     <= frac_d;
    res_idx_q  <= res_idx_d;
    res_stat_q <= res_stat_d;
    res_last_q <= res_last_d;
    out_idx_q  <= out_idx_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - CHOSEN_W){1'b0}}, out_idx_q};
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;

  // A finished walk uses up exactly one draw.
  `WSWR_ASSERT(a_walk_uses_one_draw, clk_i, rst_ni, (state_q == S_WALK && walk_done) |=> (draws_q == $past(draws_q) - 1'b1))
  // Outside the idle state entries only ever leave the round.
  `WSWR_ASSERT(a_mask_only_shrinks, clk_i, rst_ni, (state_q != S_IDLE) |=> ($countones(active_q) <= $countones($past(active_q))))
  // A burst never runs past the number of entries in use.
  `WSWR_ASSERT(a_burst_in_range, clk_i, rst_ni, (state_q == S_BURST) |-> (cnt_q < n_q))
  // The multiply step only follows a completed summing sweep.
  `WSWR_ASSERT_NEVER(a_mul_after_sum, clk_i, rst_ni, (state_q == S_MUL) && ($past(state_q) != S_SUM))

endmodule

### rtl/wswr_ram.sv
module wswr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one read port; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
